@@ sv/hsc_pkg.sv @@
// hsc_pkg: shared codes, constants and status types of the histogram clipper
// no dependencies; imported by every module of the block but hsc_ram
package hsc_pkg;

    localparam int PROP_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic
    {
        OP_ACCUM = 1'b0,
        OP_CLIP  = 1'b1
    } op_t;

    typedef enum logic
    {
        KIND_SAMPLE  = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0]
    {
        REG_LOW_BOUND       = 2'd0,
        REG_HIGH_BOUND      = 2'd1,
        REG_MEAN_VALUE      = 2'd2,
        REG_CLIP_PROPORTION = 2'd3
    } reg_idx_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ sv/hsc_ram.sv @@
// hsc_ram: generic single write port, single read port ram with registered read
// no dependencies
module hsc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ sv/hsc_div.sv @@
// hsc_div: restoring divider, one quotient bit per cycle
// depends on hsc_pkg for the status struct
module hsc_div #(
    parameter int NW = 32,
    parameter int DW = 18,
    parameter int QW = 18
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NW-1:0]      num,
    input  logic [DW-1:0]      den,
    output logic [QW-1:0]      quo,
    output hsc_pkg::div_stat_t stat
);
    import hsc_pkg::*;

    localparam int DSW = DW + QW;
    localparam int CNW = $clog2(QW);

    logic [NW-1:0]  rem_reg, rem_next;
    logic [DSW-1:0] dsh_reg, dsh_next;
    logic [QW-1:0]  quo_reg, quo_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DSW-1:0] rem_ext;

    assign rem_ext = DSW'(rem_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = DSW'(den) << (QW - 1);
            quo_next  = '0;
            cnt_next  = CNW'(QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_ext >= dsh_reg)
            begin
                rem_next = NW'(rem_ext - dsh_reg);
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ sv/hsc_queue.sv @@
// hsc_queue: two-entry request queue between front and back
// depends on hsc_pkg only by convention
module hsc_queue #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    import hsc_pkg::*;

    logic [W-1:0] mem_reg [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

endmodule

@@ sv/hsc_front.sv @@
// hsc_front: configuration registers, range narrowing and sample classification
// depends on hsc_pkg; feeds hsc_queue
module hsc_front #(
    parameter int S   = 16,
    parameter int CDW = 16,
    parameter int EW  = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CDW-1:0]                  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic signed [S-1:0]             sample,
    input  logic                            last,
    output logic                            q_valid,
    input  logic                            q_ready,
    output logic [EW-1:0]                   q_data,
    output logic [hsc_pkg::PROP_BITS-1:0]   clip_proportion
);
    import hsc_pkg::*;

    localparam int NB  = S + 2;
    localparam int SNB = S + 3;

    typedef struct packed
    {
        logic                  op;
        logic                  last;
        logic                  in_range;
        logic signed [S-1:0]   x;
        logic [NB-1:0]         off;
        logic signed [SNB-1:0] span;
        logic signed [NB-1:0]  nlo;
        logic signed [NB-1:0]  nhi;
    } entry_t;

    logic signed [S-1:0]      low_reg, high_reg, mean_reg;
    logic [PROP_BITS-1:0]     prop_reg;
    logic signed [NB-1:0]     lo_x, hi_x, mn_x, mn2, x_x;
    logic signed [NB-1:0]     up_gap, dn_gap, nlo, nhi;
    entry_t                   ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= {1'b1, {(S-1){1'b0}}};
            high_reg <= {1'b0, {(S-1){1'b1}}};
            mean_reg <= '0;
            prop_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOW_BOUND:       low_reg  <= cfg_data[S-1:0];
                REG_HIGH_BOUND:      high_reg <= cfg_data[S-1:0];
                REG_MEAN_VALUE:      mean_reg <= cfg_data[S-1:0];
                REG_CLIP_PROPORTION: prop_reg <= cfg_data[PROP_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // narrowing so that the mean sits midway
    assign lo_x   = {{2{low_reg[S-1]}}, low_reg};
    assign hi_x   = {{2{high_reg[S-1]}}, high_reg};
    assign mn_x   = {{2{mean_reg[S-1]}}, mean_reg};
    assign mn2    = {mean_reg[S-1], mean_reg, 1'b0};
    assign x_x    = {{2{sample[S-1]}}, sample};
    assign up_gap = hi_x - mn_x;
    assign dn_gap = mn_x - lo_x;
    assign nhi    = (up_gap > dn_gap) ? (mn2 - lo_x) : hi_x;
    assign nlo    = (up_gap > dn_gap) ? lo_x : (mn2 - hi_x);

    always_comb
    begin
        ent.op       = op;
        ent.last     = last;
        ent.in_range = (x_x >= nlo) && (x_x <= nhi);
        ent.x        = sample;
        ent.off      = NB'(x_x - nlo);
        ent.span     = {nhi[NB-1], nhi} - {nlo[NB-1], nlo};
        ent.nlo      = nlo;
        ent.nhi      = nhi;
    end

    assign q_data          = EW'(ent);
    assign q_valid         = in_valid;
    assign in_ready        = q_ready;
    assign clip_proportion = prop_reg;

endmodule

@@ sv/hsc_back.sv @@
// hsc_back: histogram update, bound walk, clamping and result register
// depends on hsc_pkg, hsc_ram and hsc_div
module hsc_back #(
    parameter int S        = 16,
    parameter int C        = 24,
    parameter int NUM_BINS = 1000,
    parameter int EW       = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [EW-1:0]                 q_data,
    input  logic [hsc_pkg::PROP_BITS-1:0] clip_proportion,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic signed [S-1:0]           value,
    output logic [C-1:0]                  clipped_count,
    output logic                          must_clip_more
);
    import hsc_pkg::*;

    localparam int NB   = S + 2;
    localparam int SNB  = S + 3;
    localparam int SPW  = S + 2;
    localparam int QB   = $clog2(NUM_BINS);
    localparam int NBW  = $clog2(NUM_BINS + 1);
    localparam int NW   = SPW + NBW;
    localparam int DW   = (SPW > NBW) ? SPW : NBW;
    localparam int DQ   = (SPW > QB) ? SPW : QB;
    localparam int CW   = C + QB + 1;
    localparam int TW   = PROP_BITS + C;
    localparam int CSW  = CW + PROP_BITS;
    localparam int HALF = NUM_BINS / 2;
    // reciprocal of NUM_BINS, exact for every numerator below 2^NW
    localparam int RK   = NW + QB;
    localparam int MW   = NW + 2;
    localparam int PW   = NW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << RK) + 64'(NUM_BINS) - 64'd1) / 64'(NUM_BINS));

    typedef struct packed
    {
        logic                  op;
        logic                  last;
        logic                  in_range;
        logic signed [S-1:0]   x;
        logic [NB-1:0]         off;
        logic signed [SNB-1:0] span;
        logic signed [NB-1:0]  nlo;
        logic signed [NB-1:0]  nhi;
    } entry_t;

    typedef enum logic [9:0]
    {
        ST_CLEAR     = 10'b0000000001,
        ST_IDLE      = 10'b0000000010,
        ST_BIN_DIV   = 10'b0000000100,
        ST_BIN_WR    = 10'b0000001000,
        ST_WALK_INIT = 10'b0000010000,
        ST_WALK_CHK  = 10'b0000100000,
        ST_WALK_B    = 10'b0001000000,
        ST_WALK_ADD  = 10'b0010000000,
        ST_BND_DIV   = 10'b0100000000,
        ST_SUMMARY   = 10'b1000000000
    } state_t;

    localparam logic signed [NB-1:0] SMAX_X = NB'((1 << (S - 1)) - 1);
    localparam logic signed [NB-1:0] SMIN_X = -NB'(1 << (S - 1));

    function automatic logic [C-1:0] sat_inc(input logic [C-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    state_t               state_reg, state_next;
    logic [QB-1:0]        clr_reg, clr_next;
    logic [QB-1:0]        addr_reg, addr_next;
    logic [QB-1:0]        b_reg, b_next;
    entry_t               cur_reg, cur_next;
    entry_t               ent;
    logic [C-1:0]         total_reg, total_next;
    logic [C-1:0]         outside_reg, outside_next;
    logic [TW-1:0]        target_reg, target_next;
    logic                 more_reg, more_next;
    logic [CW-1:0]        c_reg, c_next;
    logic [NW-1:0]        bnum_reg, bnum_next;
    logic [SPW-1:0]       d_reg, d_next;
    logic signed [NB-1:0] clip_lo_reg, clip_lo_next;
    logic signed [NB-1:0] clip_hi_reg, clip_hi_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic signed [S-1:0]  out_value_reg, out_value_next;
    logic [C-1:0]         out_count_reg, out_count_next;
    logic                 out_more_reg, out_more_next;

    logic                 ram_we;
    logic [QB-1:0]        ram_waddr, ram_raddr;
    logic [C-1:0]         ram_wdata, ram_rdata;
    logic                 div_start;
    logic [NW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic [DQ-1:0]        div_quo;
    div_stat_t            dstat;

    logic                 out_free;
    logic [SPW-1:0]       den_ent, den_cur, half_span, clip_dist, bquo;
    logic [PW-1:0]        bprod;
    logic [TW-1:0]        prod_now;
    logic signed [NB-1:0] x_x, clamp_r;

    assign ent       = entry_t'(q_data);
    assign out_free  = !out_valid_reg || out_ready;
    assign den_ent   = SPW'(ent.span + 1'b1);
    assign den_cur   = SPW'(cur_reg.span + 1'b1);
    assign half_span = SPW'(cur_reg.span >>> 1);
    assign prod_now  = TW'(clip_proportion) * TW'(total_reg);
    // bound offset: walked pairs times span+1, divided by NUM_BINS
    assign bprod     = PW'(bnum_reg) * PW'(RECIP);
    assign bquo      = SPW'(bprod >> RK);
    assign clip_dist = (bquo > half_span) ? half_span : bquo;
    assign x_x       = {{2{ent.x[S-1]}}, ent.x};

    always_comb
    begin
        if (x_x > clip_hi_reg)
        begin
            clamp_r = clip_hi_reg;
        end
        else if (x_x < clip_lo_reg)
        begin
            clamp_r = clip_lo_reg;
        end
        else
        begin
            clamp_r = x_x;
        end
        if (clamp_r > SMAX_X)
        begin
            clamp_r = SMAX_X;
        end
        else if (clamp_r < SMIN_X)
        begin
            clamp_r = SMIN_X;
        end
    end

    hsc_ram #(
        .WIDTH(C),
        .DEPTH(NUM_BINS)
    ) u_hist (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    hsc_div #(
        .NW(NW),
        .DW(DW),
        .QW(DQ)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .quo  (div_quo),
        .stat (dstat)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        b_next         = b_reg;
        cur_next       = cur_reg;
        total_next     = total_reg;
        outside_next   = outside_reg;
        target_next    = target_reg;
        more_next      = more_reg;
        c_next         = c_reg;
        bnum_next      = bnum_reg;
        d_next         = d_reg;
        clip_lo_next   = clip_lo_reg;
        clip_hi_next   = clip_hi_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        out_more_next  = out_more_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = '0;
        ram_raddr      = addr_reg;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        q_ready        = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == QB'(NUM_BINS - 1))
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (ent.op == OP_CLIP)
                    begin
                        if (out_free)
                        begin
                            q_ready        = 1'b1;
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_SAMPLE;
                            out_value_next = S'(clamp_r);
                            out_count_next = '0;
                            out_more_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        q_ready    = 1'b1;
                        cur_next   = ent;
                        total_next = sat_inc(total_reg);
                        if (!ent.in_range)
                        begin
                            outside_next = sat_inc(outside_reg);
                            state_next   = ent.last ? ST_WALK_INIT : ST_IDLE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            div_num    = NW'(ent.off) * NW'(NUM_BINS);
                            div_den    = DW'(den_ent);
                            state_next = ST_BIN_DIV;
                        end
                    end
                end
            end
            ST_BIN_DIV:
            begin
                if (dstat.done)
                begin
                    ram_raddr  = div_quo[QB-1:0];
                    addr_next  = div_quo[QB-1:0];
                    state_next = ST_BIN_WR;
                end
            end
            ST_BIN_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_reg;
                ram_wdata  = sat_inc(ram_rdata);
                state_next = cur_reg.last ? ST_WALK_INIT : ST_IDLE;
            end
            ST_WALK_INIT:
            begin
                target_next = prod_now;
                more_next   = ({outside_reg, PROP_BITS'(0)} > prod_now);
                c_next      = CW'(outside_reg);
                b_next      = '0;
                state_next  = ST_WALK_CHK;
            end
            ST_WALK_CHK:
            begin
                if (({c_reg, PROP_BITS'(0)} < CSW'(target_reg)) && (b_reg < QB'(HALF)))
                begin
                    ram_raddr  = b_reg;
                    state_next = ST_WALK_B;
                end
                else
                begin
                    bnum_next  = NW'(b_reg) * NW'(den_cur);
                    state_next = ST_BND_DIV;
                end
            end
            ST_WALK_B:
            begin
                c_next     = c_reg + CW'(ram_rdata);
                ram_raddr  = QB'(NUM_BINS - 1) - b_reg;
                state_next = ST_WALK_ADD;
            end
            ST_WALK_ADD:
            begin
                c_next     = c_reg + CW'(ram_rdata);
                b_next     = b_reg + 1'b1;
                state_next = ST_WALK_CHK;
            end
            ST_BND_DIV:
            begin
                // an inverted range keeps the narrowed bounds
                d_next     = (cur_reg.span < 0) ? '0 : clip_dist;
                state_next = ST_SUMMARY;
            end
            ST_SUMMARY:
            begin
                clip_lo_next = NB'(cur_reg.nlo + $signed({1'b0, d_reg}));
                clip_hi_next = NB'(cur_reg.nhi - $signed({1'b0, d_reg}));
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_SUMMARY;
                    out_value_next = '0;
                    out_count_next = (c_reg[CW-1:C] != '0) ? '1 : c_reg[C-1:0];
                    out_more_next  = more_reg;
                    total_next     = '0;
                    outside_next   = '0;
                    clr_next       = '0;
                    state_next     = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            total_reg     <= '0;
            outside_reg   <= '0;
            clip_lo_reg   <= -SMAX_X;
            clip_hi_reg   <= SMAX_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            outside_reg   <= outside_next;
            clip_lo_reg   <= clip_lo_next;
            clip_hi_reg   <= clip_hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        b_reg         <= b_next;
        cur_reg       <= cur_next;
        target_reg    <= target_next;
        more_reg      <= more_next;
        c_reg         <= c_next;
        bnum_reg      <= bnum_next;
        d_reg         <= d_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
        out_more_reg  <= out_more_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_kind_reg;
    assign value          = out_value_reg;
    assign clipped_count  = out_count_reg;
    assign must_clip_more = out_more_reg;

`ifndef SYNTHESIS
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !dstat.busy)
        else $error("divider restarted while busy");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(out_kind_reg) && $stable(out_value_reg)))
        else $error("pending result overwritten");
    a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUMMARY && out_free) |=> (state_reg == ST_CLEAR && total_reg == '0))
        else $error("summary not followed by histogram clear");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_ready && q_valid) |-> (state_reg == ST_IDLE && dstat.busy == 1'b0))
        else $error("request taken while back end busy");
`endif

endmodule

@@ sv/histogram_symmetric_clip_core.sv @@
// histogram_symmetric_clip_core: top level of the two-pass symmetric histogram clipper
// depends on hsc_pkg, hsc_front, hsc_queue and hsc_back
//
// Two-pass clipper for signed samples. The stated bounds are narrowed so that
// the mean sits midway, accumulate requests (op 0) are binned into a NUM_BINS
// histogram and the last one walks the bins in pairs from both ends to pick
// clip bounds and returns a summary; clip requests (op 1) return the sample
// clamped to those bounds. An accumulate request outside the narrowed range
// updates only the totals; one inside it goes through the bit-serial bin
// divider and the histogram ram read-modify-write. The last accumulate
// request also walks the bin pairs, scales the bounds by a reciprocal
// multiply and runs a histogram clearing sweep. After reset the same sweep
// runs before the first request is served; configuration writes are taken
// throughout.
// A two-entry queue lets requests be taken while the back end works, and the
// result register lets the next accumulate request proceed while a result waits.
module histogram_symmetric_clip_core #(
    parameter int NUM_BINS    = 1000,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [hsc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [((SAMPLE_BITS > hsc_pkg::PROP_BITS) ?
                   SAMPLE_BITS : hsc_pkg::PROP_BITS)-1:0] cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  op,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  kind,
    output logic signed [SAMPLE_BITS-1:0]         value,
    output logic [COUNT_BITS-1:0]                 clipped_count,
    output logic                                  must_clip_more
);
    import hsc_pkg::*;

    // config data width follows the widest register
    localparam int CDW = (SAMPLE_BITS > PROP_BITS) ? SAMPLE_BITS : PROP_BITS;
    // queue request: op, last, inside, sample, offset, span, both narrowed bounds
    localparam int EW  = 3 + SAMPLE_BITS + (SAMPLE_BITS + 2) + (SAMPLE_BITS + 3)
                         + 2 * (SAMPLE_BITS + 2);

    logic                 fq_valid, fq_ready;
    logic [EW-1:0]        fq_data;
    logic                 qb_valid, qb_ready;
    logic [EW-1:0]        qb_data;
    logic [PROP_BITS-1:0] prop;

    // front: registers, narrowing, classification of each request
    hsc_front #(
        .S  (SAMPLE_BITS),
        .CDW(CDW),
        .EW (EW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .sample         (sample),
        .last           (last),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_data         (fq_data),
        .clip_proportion(prop)
    );

    // short queue decouples the two halves
    hsc_queue #(
        .W(EW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_data  (fq_data),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_data (qb_data)
    );

    // back: histogram, walk, clamp and result register
    hsc_back #(
        .S       (SAMPLE_BITS),
        .C       (COUNT_BITS),
        .NUM_BINS(NUM_BINS),
        .EW      (EW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .q_data         (qb_data),
        .clip_proportion(prop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .value          (value),
        .clipped_count  (clipped_count),
        .must_clip_more (must_clip_more)
    );

endmodule
